// ----- rtl/lkv_pkg.sv -----
// Package for the LRU key-value cache: widths, codes, defaults and shared types.
package lkv_pkg;

  localparam int MAX_ENTRIES_DEF = 16;
  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = '1;

  typedef enum logic {
    FUNC_GET = 1'b0,
    FUNC_PUT = 1'b1
  } func_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } ent_t;

  typedef struct packed {
    logic shift_hit;
    logic shift_all;
    logic set_valid;
  } cell_ctrl_t;

endpackage

// ----- rtl/lru_key_value_cache_core.sv -----
// Top level of the LRU key-value cache: request handling, occupancy and the cell chain.
// Response: a get returns its word in the cycle after acceptance, from the output register.
// Throughput: one request per cycle while the response side drains; a put yields no word.
// Lookup, recency shift and insert complete in the acceptance cycle over the cell chain.
// Reset: all valid flags and occupancy clear at once, capacity returns to 16.
// Stored keys and values are not reset and are read only through valid flags.
module lru_key_value_cache_core
  import lkv_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic             func,
  input  logic [KEY_W-1:0] key,
  input  logic [VAL_W-1:0] value,
  output logic             rsp_valid,
  input  logic             rsp_ready,
  output logic             hit,
  output logic [VAL_W-1:0] read_value
);

  localparam int OW = $clog2(MAX_ENTRIES + 1);

  logic [CAP_W-1:0] capacity;
  logic [OW-1:0]    occupancy;
  logic [OW-1:0]    occupancy_next;
  logic [OW-1:0]    eff_cap;
  logic [OW-1:0]    occ_trim;

  ent_t             link_ent  [MAX_ENTRIES+1];
  logic             link_seen [MAX_ENTRIES+1];
  logic [VAL_W-1:0] link_sel  [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] valid_vec;

  logic       acc;
  logic       found;
  logic       is_get;
  cell_ctrl_t ctrl;

  assign req_ready = !rsp_valid || rsp_ready;
  assign acc       = req_valid && req_ready;
  assign is_get    = (func_t'(func) == FUNC_GET);
  assign found     = link_seen[MAX_ENTRIES];

  always_comb begin
    if (capacity == '0) begin
      eff_cap = OW'(1);
    end else if (32'(capacity) > 32'(MAX_ENTRIES)) begin
      eff_cap = OW'(MAX_ENTRIES);
    end else begin
      eff_cap = OW'(capacity);
    end
    occ_trim       = (occupancy >= eff_cap) ? (eff_cap - OW'(1)) : occupancy;
    occupancy_next = occ_trim + OW'(1);
  end

  always_comb begin
    ctrl.shift_hit = acc && found;
    ctrl.shift_all = acc && !found && !is_get;
    ctrl.set_valid = ctrl.shift_all;
  end

  assign link_ent[0].key   = key;
  assign link_ent[0].value = is_get ? link_sel[MAX_ENTRIES] : value;
  assign link_seen[0]      = 1'b0;
  assign link_sel[0]       = MISS_VALUE;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lkv_cell #(
      .IDX (i),
      .OW  (OW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .new_occ    (occupancy_next),
      .lookup_key (key),
      .prev_ent   (link_ent[i]),
      .prev_seen  (link_seen[i]),
      .prev_sel   (link_sel[i]),
      .ent        (link_ent[i+1]),
      .seen       (link_seen[i+1]),
      .sel        (link_sel[i+1]),
      .valid      (valid_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy <= '0;
    end else if (ctrl.set_valid) begin
      occupancy <= occupancy_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (acc && is_get) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && is_get) begin
      hit        <= found;
      read_value <= link_sel[MAX_ENTRIES];
    end
  end

  // thermometer of occupancy, for checking only
  logic [MAX_ENTRIES-1:0] occ_therm;
  always_comb begin
    for (int j = 0; j < MAX_ENTRIES; j++) begin
      occ_therm[j] = (OW'(j) < occupancy);
    end
  end

  a_occ_max: assert property (@(posedge clk) disable iff (rst)
    32'(occupancy) <= 32'(MAX_ENTRIES))
    else $error("occupancy above entry count");

  a_valid_therm: assert property (@(posedge clk) disable iff (rst)
    valid_vec == occ_therm)
    else $error("valid flags not contiguous with occupancy");

  a_insert_occ: assert property (@(posedge clk) disable iff (rst)
    ctrl.set_valid |=> (occupancy != '0) && valid_vec[0])
    else $error("insert left store empty");

  a_get_rsp: assert property (@(posedge clk) disable iff (rst)
    (acc && is_get) |=> rsp_valid)
    else $error("get produced no response");

  a_hit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (acc && found) |-> (occupancy != '0))
    else $error("hit on empty store");

endmodule

// ----- rtl/lkv_cell.sv -----
// One cache slot: stored entry, valid flag, key compare and recency shift.
module lkv_cell
  import lkv_pkg::*;
#(
  parameter int IDX = 0,
  parameter int OW = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  cell_ctrl_t       ctrl,
  input  logic [OW-1:0]    new_occ,
  input  logic [KEY_W-1:0] lookup_key,
  input  ent_t             prev_ent,
  input  logic             prev_seen,
  input  logic [VAL_W-1:0] prev_sel,
  output ent_t             ent,
  output logic             seen,
  output logic [VAL_W-1:0] sel,
  output logic             valid
);

  logic match;
  logic shift;

  assign match = valid && (ent.key == lookup_key);
  assign seen  = prev_seen | match;
  assign sel   = (!prev_seen && match) ? ent.value : prev_sel;
  assign shift = ctrl.shift_all | (ctrl.shift_hit & ~prev_seen);

  always_ff @(posedge clk) begin
    if (shift) begin
      ent <= prev_ent;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.set_valid) begin
      valid <= (OW'(IDX) < new_occ);
    end
  end

endmodule
